### rtl/aehs_pkg.sv
// Shared types and constants for the Ethernet header strip block.
// Used by the front, queue, back and top-level modules; no dependencies.
package aehs_pkg;

	localparam int unsigned BEAT_BITS  = 512;
	localparam int unsigned KEEP_BITS  = BEAT_BITS / 8;
	localparam int unsigned WORD_BITS  = 64;
	localparam int unsigned HDR_BYTES  = 14;
	localparam int unsigned HDR_BITS   = HDR_BYTES * 8;
	localparam int unsigned REST_BYTES = KEEP_BITS - HDR_BYTES;
	localparam int unsigned REST_BITS  = REST_BYTES * 8;

	// What the back end does with one queued beat
	typedef enum logic [1:0] {
		OP_TAIL_ONLY  = 2'd0,  // single-beat packet: bytes 14..63, last
		OP_MERGE      = 2'd1,  // held 14..63 joined with new 0..13
		OP_MERGE_LAST = 2'd2,  // merge, last, nothing left over
		OP_MERGE_TAIL = 2'd3   // merge, then a trailing beat with new 14..63
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [BEAT_BITS-1:0]  held_data;
		logic [KEEP_BITS-1:0]  held_keep;
		logic [BEAT_BITS-1:0]  cur_data;
		logic [KEEP_BITS-1:0]  cur_keep;
	} q_entry_t;

endpackage

### rtl/axis_ethernet_header_strip_top.sv
// Top level of the Ethernet header strip block.
// Instantiates aehs_front, aehs_queue and aehs_back; depends on aehs_pkg.
//
// Strips the 14-byte Ethernet header from each packet on a 512-bit stream
// and realigns the payload so it starts in byte lane 0.
// Input side is a queue write port: a beat is taken on a clock edge with push
// high and full low. Output side is a queue read port: the oldest result
// beat is shown while empty is low and is taken on an edge with pop high.
// The opening beat of a multi-beat packet produces no output; each later
// beat produces one. A final beat of a multi-beat packet with keep bit 14
// set produces an extra trailing beat from the same queue entry.
// Throughput: one beat per cycle while pop stays high, set by the single
// output register of the back end; each trailing beat takes an extra load.
// A result is written to the queue on the edge that takes the beat that
// completes it, then loaded into the output register when it is free or popped.
// When pop stays low the output register holds; the queue between front and
// back absorbs up to DEPTH more queued beats before full rises (an opening
// beat is only held in the front and takes no queue slot).
// Reset empties the queue and output register and marks the next beat as a
// packet start.
module axis_ethernet_header_strip_top import aehs_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] in_data_0,
	input  logic [63:0] in_data_1,
	input  logic [63:0] in_data_2,
	input  logic [63:0] in_data_3,
	input  logic [63:0] in_data_4,
	input  logic [63:0] in_data_5,
	input  logic [63:0] in_data_6,
	input  logic [63:0] in_data_7,
	input  logic [63:0] in_keep,
	input  logic        in_last,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] out_data_0,
	output logic [63:0] out_data_1,
	output logic [63:0] out_data_2,
	output logic [63:0] out_data_3,
	output logic [63:0] out_data_4,
	output logic [63:0] out_data_5,
	output logic [63:0] out_data_6,
	output logic [63:0] out_data_7,
	output logic [63:0] out_keep,
	output logic        out_last
);

	logic [BEAT_BITS-1:0] beat_data;
	logic [BEAT_BITS-1:0] res_data;
	q_entry_t             wr_entry;
	q_entry_t             rd_entry;
	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_empty;

	assign beat_data = {in_data_7, in_data_6, in_data_5, in_data_4,
		in_data_3, in_data_2, in_data_1, in_data_0};
	assign full = q_full;

	aehs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_full    (q_full),
		.beat_data (beat_data),
		.beat_keep (in_keep),
		.beat_last (in_last),
		.q_push    (q_push),
		.q_entry   (wr_entry)
	);

	aehs_queue #(.DEPTH(DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_entry (wr_entry),
		.rd_en    (q_pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	aehs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!q_empty),
		.q_entry  (rd_entry),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.res_data (res_data),
		.res_keep (out_keep),
		.res_last (out_last)
	);

	assign out_data_0 = res_data[0*WORD_BITS +: WORD_BITS];
	assign out_data_1 = res_data[1*WORD_BITS +: WORD_BITS];
	assign out_data_2 = res_data[2*WORD_BITS +: WORD_BITS];
	assign out_data_3 = res_data[3*WORD_BITS +: WORD_BITS];
	assign out_data_4 = res_data[4*WORD_BITS +: WORD_BITS];
	assign out_data_5 = res_data[5*WORD_BITS +: WORD_BITS];
	assign out_data_6 = res_data[6*WORD_BITS +: WORD_BITS];
	assign out_data_7 = res_data[7*WORD_BITS +: WORD_BITS];

endmodule

### rtl/aehs_front.sv
// Front end: accepts input beats, keeps the held beat and packet-start flag,
// and classifies each beat into a back-end operation. Depends on aehs_pkg.
module aehs_front import aehs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 q_full,
	input  logic [BEAT_BITS-1:0] beat_data,
	input  logic [KEEP_BITS-1:0] beat_keep,
	input  logic                 beat_last,
	output logic                 q_push,
	output q_entry_t             q_entry
);

	logic                 accept;
	logic                 at_start_q;
	logic [BEAT_BITS-1:0] held_data_q;
	logic [KEEP_BITS-1:0] held_keep_q;

	assign accept = push && !q_full;

	// The opening beat of a multi-beat packet only gets held
	assign q_push = accept && !(at_start_q && !beat_last);

	always_comb begin
		q_entry.held_data = held_data_q;
		q_entry.held_keep = held_keep_q;
		q_entry.cur_data  = beat_data;
		q_entry.cur_keep  = beat_keep;
		if (at_start_q) begin
			q_entry.op = OP_TAIL_ONLY;
		end else if (!beat_last) begin
			q_entry.op = OP_MERGE;
		end else if (beat_keep[HDR_BYTES]) begin
			q_entry.op = OP_MERGE_TAIL;
		end else begin
			q_entry.op = OP_MERGE_LAST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
		end else if (accept) begin
			at_start_q <= beat_last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_data_q <= beat_data;
			held_keep_q <= beat_keep;
		end
	end

endmodule

### rtl/aehs_queue.sv
// Short queue of classified beats between the front and back ends.
// Depends on aehs_pkg for the entry type.
module aehs_queue import aehs_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  q_entry_t wr_entry,
	input  logic     rd_en,
	output q_entry_t rd_entry,
	output logic     full,
	output logic     empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	q_entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

### rtl/aehs_back.sv
// Back end: carries out queued operations, builds realigned beats and holds
// them in the output register. Depends on aehs_pkg.
module aehs_back import aehs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  q_entry_t             q_entry,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic [BEAT_BITS-1:0] res_data,
	output logic [KEEP_BITS-1:0] res_keep,
	output logic                 res_last
);

	logic                 out_valid_q;
	logic                 phase_q;
	logic                 ready;
	logic                 load;
	logic                 emit_tail;
	logic [BEAT_BITS-1:0] nxt_data;
	logic [KEEP_BITS-1:0] nxt_keep;
	logic                 nxt_last;
	logic [BEAT_BITS-1:0] data_q;
	logic [KEEP_BITS-1:0] keep_q;
	logic                 last_q;

	assign ready = !out_valid_q || pop;
	assign load  = q_valid && ready;
	assign emit_tail = (q_entry.op == OP_TAIL_ONLY) || phase_q;

	// Hold the entry for a second beat when a trailing beat follows
	assign q_pop = load && !(q_entry.op == OP_MERGE_TAIL && !phase_q);

	always_comb begin
		if (emit_tail) begin
			nxt_data = {{HDR_BITS{1'b0}}, q_entry.cur_data[BEAT_BITS-1:HDR_BITS]};
			nxt_keep = {{HDR_BYTES{1'b0}}, q_entry.cur_keep[KEEP_BITS-1:HDR_BYTES]};
			nxt_last = 1'b1;
		end else begin
			nxt_data = {q_entry.cur_data[HDR_BITS-1:0],
				q_entry.held_data[BEAT_BITS-1:HDR_BITS]};
			nxt_keep = {q_entry.cur_keep[HDR_BYTES-1:0],
				q_entry.held_keep[KEEP_BITS-1:HDR_BYTES]};
			nxt_last = (q_entry.op == OP_MERGE_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= (q_entry.op == OP_MERGE_TAIL) && !phase_q;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= nxt_data;
			keep_q <= nxt_keep;
			last_q <= nxt_last;
		end
	end

	assign empty    = !out_valid_q;
	assign res_data = data_q;
	assign res_keep = keep_q;
	assign res_last = last_q;

endmodule

### rtl/aehs_checker.sv
// Port-level checker for the Ethernet header strip block, bound to the top
// level. Tracks owed result beats from the input side; no package needed.
module aehs_checker #(
	parameter int unsigned DEPTH = 2
) (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [63:0] in_keep,
	input logic        in_last,
	input logic        empty,
	input logic        pop,
	input logic [63:0] out_data_0,
	input logic [63:0] out_keep,
	input logic        out_last
);

	localparam int unsigned OWED_MAX = 2 * DEPTH + 1;
	localparam int unsigned OWED_W   = $clog2(OWED_MAX + 3);

	logic              in_acc;
	logic              out_acc;
	logic              start_q;
	logic [OWED_W-1:0] owed_q;
	logic [OWED_W-1:0] add;

	assign in_acc  = push && !full;
	assign out_acc = pop && !empty;

	always_comb begin
		if (!in_acc) begin
			add = '0;
		end else if (start_q) begin
			add = in_last ? OWED_W'(1) : '0;
		end else if (in_last && in_keep[14]) begin
			add = OWED_W'(2);
		end else begin
			add = OWED_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			owed_q  <= '0;
		end else begin
			if (in_acc) begin
				start_q <= in_last;
			end
			owed_q <= owed_q + add - OWED_W'(out_acc);
		end
	end

	// Reset empties both sides at once; check the edge after reset is seen
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("queue not idle during reset");

	// A stalled result beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_data_0) && $stable(out_keep)
			&& $stable(out_last))
		else $error("result beat changed while stalled");

	// No result beat shows unless one is owed
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		owed_q == '0 |-> empty)
		else $error("result beat with none owed");

	// Owed beats never exceed queue plus output register capacity
	a_owed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		owed_q <= OWED_W'(OWED_MAX))
		else $error("owed result beats exceed capacity");

endmodule

bind axis_ethernet_header_strip_top aehs_checker #(.DEPTH(DEPTH)) u_aehs_checker (.*);
